[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define ERP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("erp assertion failed");

// implication form of the above
`define ERP_ASSERT_IMP(lbl, pre, post) \
  `ERP_ASSERT(lbl, (pre) |-> (post))

`endif

[hw/rtl/erp_pkg.sv]
// types, constants and the crc step for the ethernet receive parser
package erp_pkg;

  localparam logic [31:0] CrcPoly       = 32'hEDB88320;
  localparam logic [31:0] CrcPreset     = 32'hFFFFFFFF;
  localparam logic [15:0] MaxFrameBytes = 16'hFFFF;
  localparam logic [15:0] MinFrame      = 16'd18;
  localparam logic [15:0] FcsLen        = 16'd4;
  localparam logic [15:0] HdrTagged     = 16'd18;
  localparam logic [15:0] HdrPlain      = 16'd14;

  localparam logic [15:0] TpidReset     = 16'h8100;
  localparam logic [15:0] LenLimitReset = 16'd1500;

  localparam logic [7:0] CfgTpid     = 8'd0;
  localparam logic [7:0] CfgLenLimit = 8'd1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusShort   = 2'd1;
  localparam logic [1:0] StatusOverrun = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic        has_tag;
    logic [15:0] tag_control;
    logic [15:0] type_or_length;
    logic        is_length;
    logic [31:0] fcs_received;
    logic [31:0] fcs_computed;
    logic        fcs_match;
    logic [1:0]  status;
  } res_t;

  // what the front leaves for the back: an optional payload word and an optional summary
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       has_sum;
    res_t       sum;
  } entry_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[hw/rtl/erp_front.sv]
// front end: header capture, delay line, crc and classification of each byte
module erp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  erp_pkg::in_t     in_i,
  input  logic [15:0]      tpid_i,
  input  logic [15:0]      len_limit_i,
  output logic             wr_o,
  output erp_pkg::entry_t  entry_o
);

  logic [15:0] pos_q, pos_d;
  logic [7:0]  dly_q [4];
  logic [31:0] crc_q, crc_d;
  logic [47:0] dst_q, dst_d, src_q, src_d;
  logic [15:0] ft_q, ft_d, tagw_q, tagw_d, fin_q, fin_d;
  logic        tag_q, tag_d;
  logic [15:0] hdr, idx, off;
  logic [16:0] hdr_fcs;
  logic [15:0] avail;
  logic        islen, pay;
  logic [7:0]  b;
  logic [31:0] recv, comp;
  logic [1:0]  status;

  assign b = in_i.data_byte;

  always_comb begin
    dst_d  = dst_q;
    src_d  = src_q;
    ft_d   = ft_q;
    tag_d  = tag_q;
    tagw_d = tagw_q;
    fin_d  = fin_q;
    if (pos_q < 16'd6) begin
      dst_d = {dst_q[39:0], b};
    end else if (pos_q < 16'd12) begin
      src_d = {src_q[39:0], b};
    end else if (pos_q < 16'd14) begin
      ft_d = {ft_q[7:0], b};
      if (pos_q == 16'd13) begin
        tag_d = (ft_d == tpid_i);
        if (!tag_d) fin_d = ft_d;
      end
    end else if (tag_q && pos_q < 16'd16) begin
      tagw_d = {tagw_q[7:0], b};
    end else if (tag_q && pos_q < 16'd18) begin
      fin_d = {fin_q[7:0], b};
    end

    hdr   = tag_d ? erp_pkg::HdrTagged : erp_pkg::HdrPlain;
    islen = (fin_d <= len_limit_i);

    crc_d = crc_q;
    pay   = 1'b0;
    idx   = pos_q - erp_pkg::FcsLen;
    off   = idx - hdr;
    if (pos_q >= erp_pkg::FcsLen) begin
      crc_d = erp_pkg::crc_byte(crc_q, dly_q[0]);
      if (idx >= hdr && (!islen || off < fin_d)) pay = 1'b1;
    end

    pos_d = (pos_q < erp_pkg::MaxFrameBytes) ? pos_q + 16'd1 : pos_q;

    // summary fields, used on the last byte
    recv    = {dly_q[1], dly_q[2], dly_q[3], b};
    comp    = ~crc_d;
    hdr_fcs = {1'b0, hdr} + {1'b0, erp_pkg::FcsLen};
    avail   = ({1'b0, pos_d} >= hdr_fcs) ? pos_d - hdr - erp_pkg::FcsLen : 16'd0;
    if (pos_d < erp_pkg::MinFrame)      status = erp_pkg::StatusShort;
    else if (islen && fin_d > avail)    status = erp_pkg::StatusOverrun;
    else                                status = erp_pkg::StatusOk;
  end

  always_comb begin
    wr_o                   = accept_i && (pay || in_i.last_byte);
    entry_o.has_pay        = pay;
    entry_o.pay_byte       = dly_q[0];
    entry_o.has_sum        = in_i.last_byte;
    entry_o.sum.kind           = 1'b1;
    entry_o.sum.payload_byte   = 8'd0;
    entry_o.sum.dst_mac        = dst_d;
    entry_o.sum.src_mac        = src_d;
    entry_o.sum.has_tag        = tag_d;
    entry_o.sum.tag_control    = tag_d ? tagw_d : 16'd0;
    entry_o.sum.type_or_length = fin_d;
    entry_o.sum.is_length      = islen;
    entry_o.sum.fcs_received   = recv;
    entry_o.sum.fcs_computed   = comp;
    entry_o.sum.fcs_match      = (recv == comp);
    entry_o.sum.status         = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      dly_q  <= '{default: '0};
      crc_q  <= erp_pkg::CrcPreset;
      dst_q  <= '0;
      src_q  <= '0;
      ft_q   <= '0;
      tag_q  <= 1'b0;
      tagw_q <= '0;
      fin_q  <= '0;
    end else if (accept_i) begin
      if (in_i.last_byte) begin
        pos_q  <= '0;
        dly_q  <= '{default: '0};
        crc_q  <= erp_pkg::CrcPreset;
        dst_q  <= '0;
        src_q  <= '0;
        ft_q   <= '0;
        tag_q  <= 1'b0;
        tagw_q <= '0;
        fin_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        dly_q  <= '{dly_q[1], dly_q[2], dly_q[3], b};
        crc_q  <= crc_d;
        dst_q  <= dst_d;
        src_q  <= src_d;
        ft_q   <= ft_d;
        tag_q  <= tag_d;
        tagw_q <= tagw_d;
        fin_q  <= fin_d;
      end
    end
  end

endmodule

[hw/rtl/erp_fifo.sv]
// short queue of front entries between front and back
module erp_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  erp_pkg::entry_t wr_data_i,
  input  logic            rd_i,
  output erp_pkg::entry_t rd_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  erp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CntW'(do_wr) - CntW'(do_rd);
    end
  end

endmodule

[hw/rtl/erp_back.sv]
// back end: splits queue entries into result words and holds the output register
module erp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  erp_pkg::entry_t q_data_i,
  output logic            q_rd_o,
  input  logic            pop_i,
  output logic            empty_o,
  output erp_pkg::res_t   out_o
);

  logic          out_vld_q;
  erp_pkg::res_t out_q, pay_res;
  logic          sum_next_q;
  logic          load, pay_part;

  assign load     = (!out_vld_q || pop_i) && !q_empty_i;
  assign pay_part = q_data_i.has_pay && !sum_next_q;
  assign q_rd_o   = load && !(pay_part && q_data_i.has_sum);
  assign empty_o  = !out_vld_q;
  assign out_o    = out_q;

  always_comb begin
    pay_res              = '0;
    pay_res.payload_byte = q_data_i.pay_byte;
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= pay_part ? pay_res : q_data_i.sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      sum_next_q <= 1'b0;
    end else begin
      if (load) out_vld_q <= 1'b1;
      else if (pop_i) out_vld_q <= 1'b0;
      if (load) sum_next_q <= pay_part && q_data_i.has_sum;
    end
  end

endmodule

[hw/rtl/ethernet_frame_receive_parser.sv]
// top level of the ethernet receive parser
// Ethernet II / 802.1Q receive parser. Frame bytes go in one word per cycle
// (push/full), last_byte marking the final byte; results come out of a queue
// interface (empty/pop). Each payload byte leaves as a kind 0 word, delayed
// four bytes so the FCS never appears, and padding past a length field is
// dropped; the last byte adds a kind 1 summary word with addresses, tag,
// type/length, received and computed FCS, match flag and status. One byte
// is taken every cycle while the entry queue has room; a last byte that also
// releases a payload byte yields two words, which the back end drains in
// turn, so the sustained rate is one byte per cycle while the receiver pops,
// and the entry queue depth (QueueDepth) sets how far a stalled output is absorbed.
// Configuration (tag protocol id, length limit) is always ready and is to be
// written between frames.
module ethernet_frame_receive_parser #(
  parameter int QueueDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  erp_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output erp_pkg::res_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  logic            q_full, q_empty, q_wr, q_rd, accept;
  erp_pkg::entry_t q_wdata, q_rdata;
  logic [15:0]     tpid_q, len_limit_q;

  // config registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpid_q      <= erp_pkg::TpidReset;
      len_limit_q <= erp_pkg::LenLimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        erp_pkg::CfgTpid:     tpid_q      <= cfg_data_i;
        erp_pkg::CfgLenLimit: len_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a word is taken whenever the entry queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  erp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .tpid_i      (tpid_q),
    .len_limit_i (len_limit_q),
    .wr_o        (q_wr),
    .entry_o     (q_wdata)
  );

  erp_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  erp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_data_o)
  );

endmodule

[hw/rtl/erp_checker.sv]
// port-level checks of the ethernet receive parser and their bind
`include "assert_macros.svh"

module erp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input erp_pkg::in_t  in_data_i,
  input logic          empty,
  input logic          pop,
  input erp_pkg::res_t out_data_o,
  input logic          cfg_valid_i,
  input logic          cfg_ready_o,
  input logic [7:0]    cfg_index_i,
  input logic [15:0]   cfg_data_i
);

  `ERP_ASSERT(a_hold_valid, (!empty && !pop) |=> !empty)
  `ERP_ASSERT(a_hold_word, (!empty && !pop) |=> $stable(out_data_o))
  `ERP_ASSERT_IMP(a_payload_clean, !empty && !out_data_o.kind, out_data_o.dst_mac == 48'd0 && out_data_o.status == erp_pkg::StatusOk && !out_data_o.fcs_match)
  `ERP_ASSERT_IMP(a_status_code, !empty && out_data_o.kind, out_data_o.status != 2'd3 && out_data_o.payload_byte == 8'd0)
  `ERP_ASSERT_IMP(a_fcs_flag, !empty && out_data_o.kind, out_data_o.fcs_match == (out_data_o.fcs_received == out_data_o.fcs_computed))

endmodule

bind ethernet_frame_receive_parser erp_checker u_erp_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the ethernet receive parser
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            push = 1'b0;
  logic            full;
  erp_pkg::in_t    in_data_i = '0;
  logic            empty;
  logic            pop = 1'b0;
  erp_pkg::res_t   out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [7:0]      cfg_index_i = '0;
  logic [15:0]     cfg_data_i = '0;

  ethernet_frame_receive_parser dut (.*);

  always #6 clk_i = ~clk_i;

  // frame parser mirror state
  logic [15:0] tpid_q, len_limit_q;
  logic [15:0] pos_q;
  logic [7:0]  dly_q [4];
  logic [31:0] crc_q;
  logic [47:0] dst_q, src_q;
  logic [15:0] first_type_q, tag_word_q, final_type_q;
  logic        tagged_q;

  erp_pkg::in_t  pending_words [$];
  erp_pkg::res_t expected_words [$];
  int   errors = 0;
  bit   quiet = 0;       // no idling in the final stretch
  int   hold_off = 0;    // long receiver stall, in cycles
  int   cycles = 0;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ erp_pkg::CrcPoly) : (r >> 1);
    return r;
  endfunction

  task automatic clear_frame();
    pos_q = '0;
    for (int i = 0; i < 4; i++) dly_q[i] = '0;
    crc_q = erp_pkg::CrcPreset;
    dst_q = '0; src_q = '0; first_type_q = '0; tag_word_q = '0;
    final_type_q = '0; tagged_q = 1'b0;
  endtask

  // advance the mirror by one accepted byte and queue what it produces
  task automatic parse_byte(erp_pkg::in_t w);
    logic [15:0]   p, hdr, idx, total, avail;
    logic          islen;
    logic [7:0]    leaving;
    erp_pkg::res_t r;
    p = pos_q;
    if (p < 6) dst_q = {dst_q[39:0], w.data_byte};
    else if (p < 12) src_q = {src_q[39:0], w.data_byte};
    else if (p < 14) begin
      first_type_q = {first_type_q[7:0], w.data_byte};
      if (p == 13) begin
        tagged_q = (first_type_q == tpid_q);
        if (!tagged_q) final_type_q = first_type_q;
      end
    end else if (tagged_q && p < 16) tag_word_q = {tag_word_q[7:0], w.data_byte};
    else if (tagged_q && p < 18) final_type_q = {final_type_q[7:0], w.data_byte};
    hdr = tagged_q ? erp_pkg::HdrTagged : erp_pkg::HdrPlain;
    islen = final_type_q <= len_limit_q;
    if (p >= erp_pkg::FcsLen) begin
      leaving = dly_q[0];
      idx = p - erp_pkg::FcsLen;
      crc_q = crc_step(crc_q, leaving);
      if (idx >= hdr && (!islen || (idx - hdr) < final_type_q)) begin
        r = '0;
        r.payload_byte = leaving;
        expected_words.push_back(r);
      end
    end
    dly_q[0] = dly_q[1]; dly_q[1] = dly_q[2]; dly_q[2] = dly_q[3];
    dly_q[3] = w.data_byte;
    if (p != erp_pkg::MaxFrameBytes) pos_q = p + 16'd1;
    if (w.last_byte) begin
      total = pos_q;
      avail = (total >= hdr + erp_pkg::FcsLen) ? total - hdr - erp_pkg::FcsLen : 16'd0;
      r = '0;
      r.kind = 1'b1;
      r.dst_mac = dst_q;
      r.src_mac = src_q;
      r.has_tag = tagged_q;
      r.tag_control = tagged_q ? tag_word_q : 16'd0;
      r.type_or_length = final_type_q;
      r.is_length = islen;
      r.fcs_received = {dly_q[0], dly_q[1], dly_q[2], dly_q[3]};
      r.fcs_computed = ~crc_q;
      r.fcs_match = r.fcs_received == r.fcs_computed;
      if (total < erp_pkg::MinFrame) r.status = erp_pkg::StatusShort;
      else if (islen && final_type_q > avail) r.status = erp_pkg::StatusOverrun;
      else r.status = erp_pkg::StatusOk;
      expected_words.push_back(r);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // full sampled at the rising edge, used by the driver on the next falling edge
  logic full_s = 1'b1;

  // driver: offers queued bytes with random gap bursts
  int gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && !full_s) void'(pending_words.pop_front());
      if (gap > 0) gap--;
      else if (!quiet && $urandom_range(0, 19) == 0) gap = $urandom_range(1, 12);
      push <= (gap == 0) && pending_words.size() > 0;
      if (pending_words.size() > 0) in_data_i <= pending_words[0];
    end
  end

  always @(posedge clk_i) begin
    full_s <= full;
    if (rst_ni && push && !full) parse_byte(in_data_i);
  end

  // receiver: random stalls plus one long hold-off
  int stall = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) hold_off--;
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 19) == 0) stall = $urandom_range(1, 12);
      pop <= (stall == 0) && (hold_off == 0);
    end
  end

  // monitor: compare each popped word with the oldest expectation
  always @(posedge clk_i) begin
    erp_pkg::res_t e;
    cycles++;
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word kind", {63'd0, out_data_o.kind}, 64'd0);
      end else begin
        e = expected_words.pop_front();
        if (out_data_o.kind !== e.kind) report_mismatch("kind", out_data_o.kind, e.kind);
        if (out_data_o.payload_byte !== e.payload_byte)
          report_mismatch("payload_byte", out_data_o.payload_byte, e.payload_byte);
        if (out_data_o.dst_mac !== e.dst_mac)
          report_mismatch("dst_mac", out_data_o.dst_mac, e.dst_mac);
        if (out_data_o.src_mac !== e.src_mac)
          report_mismatch("src_mac", out_data_o.src_mac, e.src_mac);
        if (out_data_o.has_tag !== e.has_tag)
          report_mismatch("has_tag", out_data_o.has_tag, e.has_tag);
        if (out_data_o.tag_control !== e.tag_control)
          report_mismatch("tag_control", out_data_o.tag_control, e.tag_control);
        if (out_data_o.type_or_length !== e.type_or_length)
          report_mismatch("type_or_length", out_data_o.type_or_length, e.type_or_length);
        if (out_data_o.is_length !== e.is_length)
          report_mismatch("is_length", out_data_o.is_length, e.is_length);
        if (out_data_o.fcs_received !== e.fcs_received)
          report_mismatch("fcs_received", out_data_o.fcs_received, e.fcs_received);
        if (out_data_o.fcs_computed !== e.fcs_computed)
          report_mismatch("fcs_computed", out_data_o.fcs_computed, e.fcs_computed);
        if (out_data_o.fcs_match !== e.fcs_match)
          report_mismatch("fcs_match", out_data_o.fcs_match, e.fcs_match);
        if (out_data_o.status !== e.status)
          report_mismatch("status", out_data_o.status, e.status);
      end
    end
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // queue one frame: header, payload, fcs (correct or not)
  task automatic queue_frame(int kind_sel, int n_pay, bit good_fcs, int len_mode);
    logic [7:0]  fr [$];
    logic [15:0] t;
    logic [31:0] c;
    for (int i = 0; i < 12; i++) fr.push_back(8'($urandom));
    t = 16'($urandom);
    if (len_mode == 0) t = n_pay[15:0];
    else if (len_mode == 1) t = 16'(n_pay + $urandom_range(1, 20));
    else if (len_mode == 2) t = 16'h0800;
    if (kind_sel == 1) begin
      fr.push_back(tpid_q[15:8]); fr.push_back(tpid_q[7:0]);
      fr.push_back(8'($urandom)); fr.push_back(8'($urandom));
    end
    fr.push_back(t[15:8]); fr.push_back(t[7:0]);
    for (int i = 0; i < n_pay; i++) fr.push_back(8'($urandom));
    c = erp_pkg::CrcPreset;
    foreach (fr[i]) c = crc_step(c, fr[i]);
    c = ~c;
    if (!good_fcs) c = $urandom;
    fr.push_back(c[31:24]); fr.push_back(c[23:16]);
    fr.push_back(c[15:8]); fr.push_back(c[7:0]);
    foreach (fr[i]) pending_words.push_back('{fr[i], i == fr.size() - 1});
  endtask

  // raw bytes of a given length, the last one marked
  task automatic queue_raw(int n);
    for (int i = 0; i < n; i++) pending_words.push_back('{8'($urandom), i == n - 1});
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || push) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == erp_pkg::CfgTpid) tpid_q = val; else len_limit_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    tpid_q = erp_pkg::TpidReset;
    len_limit_q = erp_pkg::LenLimitReset;
    clear_frame();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: short frames, tagged, length, overrun, bad fcs
    queue_raw(1); queue_raw(5); queue_raw(17); queue_raw(18); queue_raw(21);
    queue_frame(0, 10, 1, 0);
    queue_frame(1, 8, 1, 0);
    queue_frame(0, 6, 1, 1);
    queue_frame(1, 4, 0, 2);
    queue_frame(0, 3, 1, 3);
    pending_words.push_back('{8'hFF, 1'b0});
    pending_words.push_back('{8'h00, 1'b1});
    drain();

    // extreme register settings
    write_reg(erp_pkg::CfgTpid, 16'hFFFF); write_reg(erp_pkg::CfgLenLimit, 16'h0000);
    queue_frame(1, 5, 1, 0); queue_frame(0, 5, 1, 3);
    drain();
    write_reg(erp_pkg::CfgTpid, 16'h0000); write_reg(erp_pkg::CfgLenLimit, 16'hFFFF);
    queue_frame(1, 5, 1, 1); queue_frame(0, 7, 1, 3);
    drain();

    // long receiver hold-off while bytes keep coming
    write_reg(erp_pkg::CfgTpid, erp_pkg::TpidReset);
    write_reg(erp_pkg::CfgLenLimit, erp_pkg::LenLimitReset);
    hold_off = 300;
    for (int i = 0; i < 3; i++) queue_frame(i % 2, 16, 1, 2);
    drain();

    // random frames over a few settings
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        write_reg(erp_pkg::CfgTpid, 16'h88A8); write_reg(erp_pkg::CfgLenLimit, 16'd40);
      end else if (ph == 2) begin
        write_reg(erp_pkg::CfgTpid, 16'($urandom));
        write_reg(erp_pkg::CfgLenLimit, 16'($urandom_range(0, 64)));
        quiet = 1;
      end
      for (int f = 0; f < 3; f++) begin
        if ($urandom_range(0, 7) == 0) queue_raw($urandom_range(1, 25));
        else queue_frame($urandom_range(0, 1), $urandom_range(0, 16),
                         $urandom_range(0, 3) != 0, $urandom_range(0, 3));
      end
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

[ethernet_frame_receive_parser.f]
+incdir+hw/rtl
hw/rtl/erp_pkg.sv
hw/rtl/erp_front.sv
hw/rtl/erp_fifo.sv
hw/rtl/erp_back.sv
hw/rtl/ethernet_frame_receive_parser.sv
hw/rtl/erp_checker.sv
tb/testbench.sv
